[rtl/core/cdnc_pkg.sv]
package cdnc_pkg;

  // Field widths of one word on either side.
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int DN_W     = 23;
  localparam int SOD_W    = 17;
  localparam int DATA_W   = 80;

  localparam logic [SOD_W-1:0] SECS_PER_DAY = 17'd86400;

  // Constant division by reciprocal multiplication. For an operand below 2^XW and a
  // divisor below 2^DW, a shift of XW + DW with a rounded-up reciprocal is exact.
  localparam int Q100_S = 22;
  localparam longint unsigned Q100_R = ((64'd1 << Q100_S) + 64'd99) / 64'd100;
  localparam int Q100_RW = $clog2(Q100_R + 1);

  localparam int DIVN_S = 41;
  localparam longint unsigned DIVN_R = ((64'd4 << DIVN_S) + 64'd146096) / 64'd146097;
  localparam int DIVN_RW = $clog2(DIVN_R + 1);

  localparam int DIVI_S = 37;
  localparam longint unsigned DIVI_R =
    ((64'd4000 << DIVI_S) + 64'd1461000) / 64'd1461001;
  localparam int DIVI_RW = $clog2(DIVI_R + 1);

  localparam int DIVJ_S = 21;
  localparam longint unsigned DIVJ_R = ((64'd80 << DIVJ_S) + 64'd2446) / 64'd2447;
  localparam int DIVJ_RW = $clog2(DIVJ_R + 1);

  localparam int HOUR_S = 29;
  localparam longint unsigned HOUR_R = ((64'd1 << HOUR_S) + 64'd3599) / 64'd3600;
  localparam int HOUR_RW = $clog2(HOUR_R + 1);

  localparam int MIN_S = 18;
  localparam longint unsigned MIN_R = ((64'd1 << MIN_S) + 64'd59) / 64'd60;
  localparam int MIN_RW = $clog2(MIN_R + 1);

  // Results that are finished early ride along the pipeline in this record.
  typedef struct packed {
    logic                cmd;
    logic                oor;
    logic [DN_W-1:0]     dn;
    logic [SOD_W-1:0]    sod;
    logic [HOUR_W-1:0]   hour;
    logic [MINUTE_W-1:0] minute;
    logic [SECOND_W-1:0] second;
  } res_t;

  // Month term 367 * (m - 2 - 12a) / 12 of the forward formula.
  function automatic logic [8:0] cal_mon_term(input logic [MONTH_W-1:0] m);
    logic [8:0] v;
    case (m)
      4'd0:    v = 9'd305;
      4'd1:    v = 9'd336;
      4'd2:    v = 9'd367;
      4'd3:    v = 9'd30;
      4'd4:    v = 9'd61;
      4'd5:    v = 9'd91;
      4'd6:    v = 9'd122;
      4'd7:    v = 9'd152;
      4'd8:    v = 9'd183;
      4'd9:    v = 9'd214;
      4'd10:   v = 9'd244;
      4'd11:   v = 9'd275;
      4'd12:   v = 9'd305;
      4'd13:   v = 9'd336;
      4'd14:   v = 9'd367;
      4'd15:   v = 9'd397;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // Day offset 2447 * j / 80 of the reverse formula.
  function automatic logic [8:0] cal_day_ofs(input logic [3:0] j);
    logic [8:0] v;
    case (j)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd30;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd91;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd152;
      4'd6:    v = 9'd183;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd244;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd305;
      4'd11:   v = 9'd336;
      4'd12:   v = 9'd367;
      4'd13:   v = 9'd397;
      4'd14:   v = 9'd428;
      4'd15:   v = 9'd458;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/calendar_day_number_converter.sv]
// A word accepted at the input passes through each stage register in order to the output.
// Throughput: one word per cycle while m_tready is high; every stage is a register
// with its own valid bit, and a stage loads whenever it is empty or the stage behind
// it moves on. Reset clears all valid bits; payload registers are not reset.
module calendar_day_number_converter import cdnc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // Fields from bit 0 up: year_in, month_in, day_in, hour_in, minute_in,
  // second_in, day_number_in, second_of_day_in.
  input  logic [DATA_W-1:0] s_tdata,
  // Field: cmd.
  input  logic              s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  // Fields from bit 0 up: day_number_out, second_of_day_out, year_out, month_out,
  // day_out, hour_out, minute_out, second_out.
  output logic [DATA_W-1:0] m_tdata,
  // Field: out_of_range.
  output logic              m_tuser
);

  localparam int NST = 10;

  localparam int P3_W = 15 + Q100_RW;
  localparam int HP_W = SOD_W + HOUR_RW;
  localparam int PN_W = DN_W + DIVN_RW;
  localparam int MP_W = 12 + MIN_RW;
  localparam int PI_W = 16 + DIVI_RW;
  localparam int PJ_W = 9 + DIVJ_RW;

  // Day number of the epoch plus the constant term of the forward formula.
  localparam logic [DN_W-1:0] EPOCH_OFS = 23'd2483620;
  // Offset from the day number to the l term of the reverse formula.
  localparam logic signed [23:0] L_OFS   = 24'sd2520114;
  localparam logic signed [23:0] DAY_MIN = -24'sd730119;
  localparam logic signed [23:0] DAY_MAX = 24'sd2921939;

  // Handshake: a stage takes new contents when it is empty or drains this cycle.
  logic [NST:1]   vld;
  logic [NST+1:1] en;

  assign en[NST+1] = m_tready;

  for (genvar k = 1; k <= NST; k++) begin : g_en
    assign en[k] = ~vld[k] | en[k+1];
  end

  assign s_tready = en[1];
  assign m_tvalid = vld[NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= s_tvalid;
      end
      for (int k = 2; k <= NST; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Input fields.
  logic [YEAR_W-1:0]   year_in;
  logic [MONTH_W-1:0]  month_in;
  logic [DAY_W-1:0]    day_in;
  logic [HOUR_W-1:0]   hour_in;
  logic [MINUTE_W-1:0] minute_in;
  logic [SECOND_W-1:0] second_in;
  logic [DN_W-1:0]     day_number_in;
  logic [SOD_W-1:0]    second_of_day_in;

  assign year_in          = s_tdata[13:0];
  assign month_in         = s_tdata[17:14];
  assign day_in           = s_tdata[22:18];
  assign hour_in          = s_tdata[27:23];
  assign minute_in        = s_tdata[33:28];
  assign second_in        = s_tdata[39:34];
  assign day_number_in    = s_tdata[62:40];
  assign second_of_day_in = s_tdata[79:63];

  // The record of early results; stage k owns rs[k].
  res_t rs [1:NST-1];
  res_t rs1_next;

  always_comb begin
    rs1_next     = '0;
    rs1_next.cmd = s_tuser;
  end

  // Stage 1. Both conversions are worked on for every word and the command picks
  // the result at the end. The forward path folds the month correction a, which
  // is -1 for January and February, into the two year sums, and sums the time of
  // day into seconds. The reverse path carries a full extra day of seconds into
  // the day number.
  logic [14:0]        ya_s1, yb_s1;
  logic [8:0]         mt_s1;
  logic [DAY_W-1:0]   d_s1;
  logic [SOD_W-1:0]   secs_s1;
  logic signed [23:0] dn_s1;
  logic [SOD_W-1:0]   s_s1;
  logic               sod_carry;

  assign sod_carry = (second_of_day_in >= SECS_PER_DAY);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      rs[1]   <= rs1_next;
      ya_s1   <= {1'b0, year_in} + ((month_in <= 4'd2) ? 15'd4799 : 15'd4800);
      yb_s1   <= {1'b0, year_in} + ((month_in <= 4'd2) ? 15'd4899 : 15'd4900);
      mt_s1   <= cal_mon_term(month_in);
      d_s1    <= day_in;
      secs_s1 <= SOD_W'(hour_in) * 17'd3600 + SOD_W'(minute_in) * 17'd60
               + SOD_W'(second_in);
      dn_s1   <= {day_number_in[DN_W-1], day_number_in} + {23'd0, sod_carry};
      s_s1    <= sod_carry ? (second_of_day_in - SECS_PER_DAY) : second_of_day_in;
    end
  end

  // Stage 2. The forward path starts the year products and folds the day, the
  // month term, the day carry and all constants into one base value. The reverse
  // path checks the day against years 1 to 9999 and starts the hour division.
  logic [24:0]        p1_s2;
  logic [P3_W-1:0]    p3_s2;
  logic [DN_W-1:0]    base_s2;
  logic [DN_W-1:0]    l_s2;
  logic [HP_W-1:0]    hp_s2;
  logic [SOD_W-1:0]   s_s2;
  logic               secs_carry;
  res_t               rs2_next;

  assign secs_carry = (secs_s1 >= SECS_PER_DAY);

  always_comb begin
    rs2_next     = rs[1];
    rs2_next.sod = secs_carry ? (secs_s1 - SECS_PER_DAY) : secs_s1;
    rs2_next.oor = (dn_s1 < DAY_MIN) || (dn_s1 > DAY_MAX);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rs[2]     <= rs2_next;
      p1_s2     <= 25'(ya_s1) * 25'd1461;
      p3_s2     <= P3_W'(yb_s1) * P3_W'(Q100_R);
      base_s2   <= DN_W'(d_s1) + DN_W'(mt_s1) + DN_W'(secs_carry) - EPOCH_OFS;
      l_s2      <= DN_W'(dn_s1 + L_OFS);
      hp_s2     <= HP_W'(s_s1) * HP_W'(HOUR_R);
      s_s2      <= s_s1;
    end
  end

  // Stage 3. Year terms of the forward formula; the century division of the
  // reverse formula and the hour.
  logic [DN_W-1:0]  t1_s3;
  logic [8:0]       t3_s3;
  logic [DN_W-1:0]  base_s3;
  logic [PN_W-1:0]  pn_s3;
  logic [DN_W-1:0]  l_s3;
  logic [SOD_W-1:0] s_s3;
  logic [7:0]       cent;
  res_t             rs3_next;

  assign cent = p3_s2[Q100_S +: 8];

  always_comb begin
    rs3_next      = rs[2];
    rs3_next.hour = hp_s2[HOUR_S +: HOUR_W];
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      rs[3]      <= rs3_next;
      t1_s3      <= p1_s2[24:2];
      t3_s3      <= 9'((10'(cent) * 10'd3) >> 2);
      base_s3    <= base_s2;
      pn_s3      <= PN_W'(l_s2) * PN_W'(DIVN_R);
      l_s3       <= l_s2;
      s_s3       <= s_s2;
    end
  end

  // Stage 4. The forward day number is complete. The reverse path has n, the
  // count of centuries, and removes them next; the remainder of the hour
  // is kept for the minute division.
  logic [24:0]  m1_s4;
  logic [14:0]  y100_s4;
  logic [DN_W-1:0] l_s4;
  logic [11:0]  r_s4;
  logic [7:0]   n_cyc;
  res_t         rs4_next;

  assign n_cyc = pn_s3[DIVN_S +: 8];

  always_comb begin
    rs4_next    = rs[3];
    rs4_next.dn = t1_s3 - DN_W'(t3_s3) + base_s3;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      rs[4]    <= rs4_next;
      m1_s4    <= 25'(n_cyc) * 25'd146097 + 25'd3;
      y100_s4  <= 15'(n_cyc) * 15'd100;
      l_s4     <= l_s3;
      r_s4     <= 12'(s_s3 - SOD_W'(rs[3].hour) * 17'd3600);
    end
  end

  // Stage 5. Day within the century, plus one, ready for the division
  // that finds the year within the century.
  logic [15:0]     l2p1_s5;
  logic [MP_W-1:0] mp_s5;
  logic [11:0]     r_s5;
  logic [14:0]     y100_s5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      rs[5]   <= rs[4];
      l2p1_s5 <= 16'(l_s4 - m1_s4[24:2] + 23'd1);
      mp_s5   <= MP_W'(r_s4) * MP_W'(MIN_R);
      r_s5    <= r_s4;
      y100_s5 <= y100_s4;
    end
  end

  // Stage 6.
  logic [PI_W-1:0] pi_s6;
  logic [15:0]     l2p1_s6;
  logic [11:0]     r_s6;
  logic [14:0]     y100_s6;
  res_t            rs6_next;

  always_comb begin
    rs6_next        = rs[5];
    rs6_next.minute = mp_s5[MIN_S +: MINUTE_W];
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      rs[6]        <= rs6_next;
      pi_s6        <= PI_W'(l2p1_s5) * PI_W'(DIVI_R);
      l2p1_s6      <= l2p1_s5;
      r_s6         <= r_s5;
      y100_s6      <= y100_s5;
    end
  end

  // Stage 7. The year within the century, i, and 1461 * i, from which the days before that year follow.
  logic [6:0]  i_s7;
  logic [17:0] m2_s7;
  logic [15:0] l2p1_s7;
  logic [14:0] y100_s7;
  logic [6:0]  yr_cyc;
  res_t        rs7_next;

  assign yr_cyc = pi_s6[DIVI_S +: 7];

  always_comb begin
    rs7_next        = rs[6];
    rs7_next.second = 6'(r_s6 - 12'(rs[6].minute) * 12'd60);
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      rs[7]        <= rs7_next;
      i_s7         <= yr_cyc;
      m2_s7        <= 18'(yr_cyc) * 18'd1461;
      l2p1_s7      <= l2p1_s6;
      y100_s7      <= y100_s6;
    end
  end

  // Stage 8. Day of the year counted from March, offset by 31, and the year
  // before the January and February correction.
  logic [8:0]        l3_s8;
  logic [YEAR_W-1:0] ybase_s8;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      rs[8]    <= rs[7];
      l3_s8    <= 9'(l2p1_s7 + 16'd30 - m2_s7[17:2]);
      ybase_s8 <= 14'(y100_s7 + 15'(i_s7) - 15'd4900);
    end
  end

  // Stage 9. Month division.
  logic [PJ_W-1:0]   pj_s9;
  logic [8:0]        l3_s9;
  logic [YEAR_W-1:0] ybase_s9;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      rs[9]    <= rs[8];
      pj_s9    <= PJ_W'(l3_s8) * PJ_W'(DIVJ_R);
      l3_s9    <= l3_s8;
      ybase_s9 <= ybase_s8;
    end
  end

  // Stage 10. Month and day, then the output word. A month index of 11 or 12
  // stands for January or February of the next year. Fields that the command
  // does not produce are zero, and so is every calendar field of a day outside
  // years 1 to 9999.
  logic [3:0]          jm;
  logic                next_yr;
  logic                cal_ok;
  logic [DAY_W-1:0]    day_c;
  logic [MONTH_W-1:0]  mon_c;
  logic [YEAR_W-1:0]   year_c;
  logic [DN_W-1:0]     dn_o;
  logic [SOD_W-1:0]    sod_o;
  logic [YEAR_W-1:0]   year_o;
  logic [MONTH_W-1:0]  mon_o;
  logic [DAY_W-1:0]    day_o;
  logic [HOUR_W-1:0]   hour_o;
  logic [MINUTE_W-1:0] min_o;
  logic [SECOND_W-1:0] sec_o;

  always_comb begin
    jm      = pj_s9[DIVJ_S +: 4];
    next_yr = (jm >= 4'd11);
    day_c   = 5'(l3_s9 - cal_day_ofs(jm));
    mon_c   = next_yr ? (jm - 4'd10) : (jm + 4'd2);
    year_c  = ybase_s9 + YEAR_W'(next_yr);
    cal_ok  = rs[9].cmd && !rs[9].oor;
    dn_o    = rs[9].cmd ? '0 : rs[9].dn;
    sod_o   = rs[9].cmd ? '0 : rs[9].sod;
    year_o  = cal_ok ? year_c : '0;
    mon_o   = cal_ok ? mon_c : '0;
    day_o   = cal_ok ? day_c : '0;
    hour_o  = cal_ok ? rs[9].hour : '0;
    min_o   = cal_ok ? rs[9].minute : '0;
    sec_o   = cal_ok ? rs[9].second : '0;
  end

  always_ff @(posedge clk) begin
    if (en[NST]) begin
      m_tdata <= {sec_o, min_o, hour_o, day_o, mon_o, year_o, sod_o, dn_o};
      m_tuser <= rs[9].cmd & rs[9].oor;
    end
  end

endmodule
